@@ rtl/lrs_pkg.sv @@
// lrs_pkg: shared types, constants and time helpers of the link reconnect supervisor
// used by lrs_delay and link_reconnect_supervisor_core; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DELAY_W = 22;
    localparam int unsigned STEP_W  = 3;

    localparam logic [STEP_W-1:0]  BACKOFF_STEPS     = 3'd5;
    localparam logic [TIME_W-1:0]  RETRY_INTERVAL_MS = 32'd1800000;
    localparam logic [DELAY_W-1:0] PROBE_TIMEOUT_MS  = 22'd15000;
    localparam logic [DELAY_W-1:0] IDLE_DELAY_MS     = 22'd60000;
    localparam logic [DELAY_W-1:0] DELAY_MAX         = 22'h3FFFFF;
    localparam logic [DELAY_W-1:0] CONNECT_TIMEOUT_RESET = 22'd20000;

    // configuration register indexes
    localparam logic CFG_CONNECT_TIMEOUT     = 1'b0;
    localparam logic CFG_CREDENTIALS_PRESENT = 1'b1;

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_START     = 2'd1,
        REQ_RECONNECT = 2'd2,
        REQ_UNUSED    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        MODE_AP         = 2'd0,
        MODE_CONNECTING = 2'd1,
        MODE_CONNECTED  = 2'd2,
        MODE_IDLE       = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE          = 3'd0,
        ACT_CONNECT_FORCE = 3'd1,
        ACT_CONNECT_PLAIN = 3'd2,
        ACT_ENTER_AP      = 3'd3,
        ACT_CONNECTED     = 3'd4
    } action_t;

    // supervisor state seen by the delay calculation
    typedef struct packed {
        mode_t              mode;
        logic [TIME_W-1:0]  attempt_start;
        logic [DELAY_W-1:0] attempt_timeout;
        logic [STEP_W-1:0]  backoff_step;
        logic               retry_armed;
        logic [TIME_W-1:0]  retry_due;
    } sup_state_t;

    // re-issue schedule, steps past the fifth repeat the last delay
    function automatic logic [DELAY_W-1:0] sched_at(input logic [STEP_W-1:0] step);
        logic [DELAY_W-1:0] d;
        case (step)
            3'd0:    d = 22'd1000;
            3'd1:    d = 22'd3000;
            3'd2:    d = 22'd7000;
            3'd3:    d = 22'd15000;
            default: d = 22'd29000;
        endcase
        return d;
    endfunction

    // deadline reached when the wrapped difference is non-negative
    function automatic logic reached(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] target);
        logic [TIME_W-1:0] diff;
        diff = now - target;
        return ~diff[TIME_W-1];
    endfunction

    function automatic logic [TIME_W-1:0] time_left(input logic [TIME_W-1:0] now,
                                                    input logic [TIME_W-1:0] target);
        logic [TIME_W-1:0] left;
        left = target - now;
        return reached(now, target) ? '0 : left;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lrs_delay.sv @@
// lrs_delay: time until the next pending action, from the updated supervisor state
// depends on lrs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrs_delay import lrs_pkg::*;
(
    input  wire sup_state_t         st,
    input  wire logic               cred,
    input  wire logic [TIME_W-1:0]  now,
    output logic [DELAY_W-1:0]      delay
);

    logic [TIME_W-1:0] to_left;
    logic [TIME_W-1:0] bo_left;
    logic [TIME_W-1:0] ap_left;
    logic [TIME_W-1:0] conn_left;

    always_comb
    begin
        to_left = time_left(now, st.attempt_start + {{(TIME_W-DELAY_W){1'b0}}, st.attempt_timeout});
        bo_left = time_left(now, st.attempt_start
                                 + {{(TIME_W-DELAY_W){1'b0}}, sched_at(st.backoff_step)});
        ap_left = time_left(now, st.retry_due);
        conn_left = to_left;
        if (st.backoff_step < BACKOFF_STEPS && bo_left < to_left)
        begin
            conn_left = bo_left;
        end
    end

    always_comb
    begin
        case (st.mode)
            MODE_AP:
            begin
                if (!st.retry_armed || !cred)
                    delay = IDLE_DELAY_MS;
                else if (ap_left > {{(TIME_W-DELAY_W){1'b0}}, DELAY_MAX})
                    delay = DELAY_MAX;
                else
                    delay = ap_left[DELAY_W-1:0];
            end
            MODE_CONNECTING:
            begin
                if (conn_left > {{(TIME_W-DELAY_W){1'b0}}, DELAY_MAX})
                    delay = DELAY_MAX;
                else
                    delay = conn_left[DELAY_W-1:0];
            end
            default:
            begin
                delay = IDLE_DELAY_MS;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/link_reconnect_supervisor_core.sv @@
// link_reconnect_supervisor_core: top level of the link reconnect supervisor
// depends on lrs_pkg and lrs_delay
`timescale 1ns / 1ps
`default_nettype none

// Supervises a radio link through not started, access-point fallback, connecting and
// connected modes. One transaction (tick, start or reconnect request) is taken every
// clock cycle while in_stall is low, and each gives exactly one result transaction,
// passing through an input register, a stage in which the mode and attempt state
// are updated, and a stage in which the delay to the next pending action is worked
// out from the updated state into the result register. Each stage holds its transaction
// only while the stage after it is full and stalled, so input is still taken while a
// result waits, until the earlier stages are full. Configuration writes take effect on
// the next clock and must be made while no transaction is in flight.

module link_reconnect_supervisor_core import lrs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [DELAY_W-1:0] cfg_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic [TIME_W-1:0]  now_ms,
    input  wire logic               link_up,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              mode_now,
    output logic [2:0]              action,
    output logic                    issue_reconnect,
    output logic                    accepted,
    output logic [DELAY_W-1:0]      next_delay_ms
);

    // configuration
    logic [DELAY_W-1:0] timeout_reg;
    logic               cred_reg;

    // stage 0: input register
    logic               v0_reg;
    req_t               req0_reg;
    logic [TIME_W-1:0]  now0_reg;
    logic               up0_reg;

    // stage 1: updated state plus per-transaction flags
    logic               v1_reg;
    logic [TIME_W-1:0]  now1_reg;
    action_t            act1_reg;
    logic               reissue1_reg;
    logic               acc1_reg;

    // stage 2: result register
    logic               v2_reg;
    mode_t              mode2_reg;
    action_t            act2_reg;
    logic               reissue2_reg;
    logic               acc2_reg;
    logic [DELAY_W-1:0] delay2_reg;

    sup_state_t         st_reg;
    sup_state_t         st_next;

    logic               ready0;
    logic               ready1;
    logic               ready2;
    logic               go0;

    logic [TIME_W-1:0]  elapsed;
    logic               bo_due;
    logic               to_due;
    logic               retry_hit;
    action_t            act_next;
    logic               reissue_next;
    logic               acc_next;
    logic [DELAY_W-1:0] delay_calc;

    assign ready2   = !v2_reg || !out_stall;
    assign ready1   = !v1_reg || ready2;
    assign ready0   = !v0_reg || ready1;
    assign in_stall = !ready0;
    assign go0      = v0_reg && ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= CONNECT_TIMEOUT_RESET;
            cred_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CONNECT_TIMEOUT:
                begin
                    timeout_reg <= (cfg_data == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : cfg_data;
                end
                CFG_CREDENTIALS_PRESENT:
                begin
                    cred_reg <= cfg_data[0];
                end
                default:
                begin
                    cred_reg <= cred_reg;
                end
            endcase
        end
    end

    // decision terms for the transaction in stage 0
    assign elapsed   = now0_reg - st_reg.attempt_start;
    assign bo_due    = (st_reg.backoff_step < BACKOFF_STEPS)
                       && (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, sched_at(st_reg.backoff_step)});
    assign to_due    = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, st_reg.attempt_timeout};
    assign retry_hit = cred_reg && st_reg.retry_armed && reached(now0_reg, st_reg.retry_due);

    // next state
    always_comb
    begin
        st_next = st_reg;
        if (go0)
        begin
            case (req0_reg)
                REQ_START:
                begin
                    st_next.attempt_start = now0_reg;
                    st_next.backoff_step  = '0;
                    st_next.retry_armed   = 1'b0;
                    st_next.retry_due     = '0;
                    if (cred_reg)
                    begin
                        st_next.mode            = MODE_CONNECTING;
                        st_next.attempt_timeout = timeout_reg;
                    end
                    else
                    begin
                        st_next.mode            = MODE_AP;
                        st_next.attempt_start   = '0;
                        st_next.attempt_timeout = '0;
                    end
                end
                REQ_RECONNECT:
                begin
                    if (st_reg.mode != MODE_IDLE && cred_reg)
                    begin
                        st_next.mode            = MODE_CONNECTING;
                        st_next.attempt_start   = now0_reg;
                        st_next.attempt_timeout = timeout_reg;
                        st_next.backoff_step    = '0;
                        st_next.retry_armed     = 1'b0;
                        st_next.retry_due       = '0;
                    end
                end
                REQ_TICK:
                begin
                    case (st_reg.mode)
                        MODE_AP:
                        begin
                            if (retry_hit)
                            begin
                                st_next.mode            = MODE_CONNECTING;
                                st_next.attempt_start   = now0_reg;
                                st_next.attempt_timeout = PROBE_TIMEOUT_MS;
                                st_next.backoff_step    = '0;
                                st_next.retry_armed     = 1'b0;
                                st_next.retry_due       = '0;
                            end
                        end
                        MODE_CONNECTED:
                        begin
                            if (cred_reg && !up0_reg)
                            begin
                                st_next.mode            = MODE_CONNECTING;
                                st_next.attempt_start   = now0_reg;
                                st_next.attempt_timeout = timeout_reg;
                                st_next.backoff_step    = '0;
                                st_next.retry_armed     = 1'b0;
                                st_next.retry_due       = '0;
                            end
                        end
                        MODE_CONNECTING:
                        begin
                            if (cred_reg && up0_reg)
                            begin
                                st_next.mode            = MODE_CONNECTED;
                                st_next.attempt_start   = '0;
                                st_next.attempt_timeout = '0;
                                st_next.backoff_step    = '0;
                                st_next.retry_armed     = 1'b0;
                                st_next.retry_due       = '0;
                            end
                            else if (cred_reg)
                            begin
                                if (bo_due)
                                    st_next.backoff_step = st_reg.backoff_step + 3'd1;
                                // timeout falls back and arms the long retry probe
                                if (to_due)
                                begin
                                    st_next.mode            = MODE_AP;
                                    st_next.attempt_start   = '0;
                                    st_next.attempt_timeout = '0;
                                    st_next.backoff_step    = '0;
                                    st_next.retry_armed     = 1'b1;
                                    st_next.retry_due       = now0_reg + RETRY_INTERVAL_MS;
                                end
                            end
                        end
                        default:
                        begin
                            st_next = st_reg;
                        end
                    endcase
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
        end
    end

    // per-transaction outputs
    always_comb
    begin
        act_next     = ACT_NONE;
        reissue_next = 1'b0;
        acc_next     = 1'b0;
        case (req0_reg)
            REQ_START:
            begin
                act_next = cred_reg ? ACT_CONNECT_FORCE : ACT_ENTER_AP;
            end
            REQ_RECONNECT:
            begin
                if (st_reg.mode != MODE_IDLE && cred_reg)
                begin
                    act_next = ACT_CONNECT_FORCE;
                    acc_next = 1'b1;
                end
            end
            REQ_TICK:
            begin
                case (st_reg.mode)
                    MODE_AP:
                    begin
                        if (retry_hit)
                            act_next = ACT_CONNECT_FORCE;
                    end
                    MODE_CONNECTED:
                    begin
                        if (cred_reg && !up0_reg)
                            act_next = ACT_CONNECT_PLAIN;
                    end
                    MODE_CONNECTING:
                    begin
                        if (cred_reg && up0_reg)
                        begin
                            act_next = ACT_CONNECTED;
                        end
                        else if (cred_reg)
                        begin
                            reissue_next = bo_due;
                            if (to_due)
                                act_next = ACT_ENTER_AP;
                        end
                    end
                    default:
                    begin
                        act_next = ACT_NONE;
                    end
                endcase
            end
            default:
            begin
                act_next = ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode            <= MODE_IDLE;
            st_reg.attempt_start   <= '0;
            st_reg.attempt_timeout <= '0;
            st_reg.backoff_step    <= '0;
            st_reg.retry_armed     <= 1'b0;
            st_reg.retry_due       <= '0;
            v0_reg                 <= 1'b0;
            v1_reg                 <= 1'b0;
            v2_reg                 <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (ready0)
                v0_reg <= in_valid;
            if (ready1)
                v1_reg <= v0_reg;
            if (ready2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready0)
        begin
            req0_reg <= req_t'(req_type);
            now0_reg <= now_ms;
            up0_reg  <= link_up;
        end
        if (ready1)
        begin
            now1_reg     <= now0_reg;
            act1_reg     <= act_next;
            reissue1_reg <= reissue_next;
            acc1_reg     <= acc_next;
        end
        if (ready2)
        begin
            mode2_reg    <= st_reg.mode;
            act2_reg     <= act1_reg;
            reissue2_reg <= reissue1_reg;
            acc2_reg     <= acc1_reg;
            delay2_reg   <= delay_calc;
        end
    end

    lrs_delay u_delay
    (
        .st    (st_reg),
        .cred  (cred_reg),
        .now   (now1_reg),
        .delay (delay_calc)
    );

    assign out_valid       = v2_reg;
    assign mode_now        = mode2_reg;
    assign action          = act2_reg;
    assign issue_reconnect = reissue2_reg;
    assign accepted        = acc2_reg;
    assign next_delay_ms   = delay2_reg;

endmodule

`default_nettype wire
